// File: src/htm_pkg.sv
// ----------------------------------------------------------------------------
// htm_pkg
// Shared types and constants of the handle table mailbox block.
// ----------------------------------------------------------------------------
package htm_pkg;

    localparam int ENTRIES_DEFAULT = 8;
    localparam int QUEUE_DEPTH     = 2;

    localparam int HANDLE_W = 32;
    localparam int WORD_W   = 64;
    localparam int CNT_W    = 32;

    localparam logic [CNT_W-1:0]    CNT_MAX    = '1;
    localparam logic [HANDLE_W-1:0] HANDLE_MAX = '1;
    localparam logic [1:0]          TYPE_MAX   = 2'd1;

    // request codes on the input channel
    localparam logic [2:0] REQ_ADD  = 3'd0;
    localparam logic [2:0] REQ_DEL  = 3'd1;
    localparam logic [2:0] REQ_SEND = 3'd2;
    localparam logic [2:0] REQ_RECV = 3'd3;
    localparam logic [2:0] REQ_STAT = 3'd4;

    // classified command handed from the front to the back
    typedef enum logic [2:0] {
        OP_FAIL,
        OP_ADD,
        OP_DEL,
        OP_SEND,
        OP_RECV,
        OP_STAT
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [HANDLE_W-1:0] new_handle;
        logic [WORD_W-1:0]   value;
    } t_cmd;

    typedef enum logic {
        F_IDLE,
        F_EXEC
    } t_fstate;

    typedef enum logic {
        B_IDLE,
        B_EXEC
    } t_bstate;

endpackage

// File: src/htm_if.sv
// ----------------------------------------------------------------------------
// htm_req_if / htm_rsp_if
// Valid/ready channels for requests and results of the handle table.
// ----------------------------------------------------------------------------
interface htm_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [1:0]  iface_type;
    logic [31:0] handle;
    logic [63:0] send_value;

    modport source (output valid, output req_type, output iface_type,
                    output handle, output send_value, input ready);
    modport sink   (input valid, input req_type, input iface_type,
                    input handle, input send_value, output ready);
endinterface

interface htm_rsp_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [31:0] new_handle;
    logic [63:0] recv_value;
    logic [31:0] sent_total;
    logic [31:0] recv_total;

    modport source (output valid, output status, output new_handle,
                    output recv_value, output sent_total, output recv_total,
                    input ready);
    modport sink   (input valid, input status, input new_handle,
                    input recv_value, input sent_total, input recv_total,
                    output ready);
endinterface

// File: src/htm_ram.sv
// ----------------------------------------------------------------------------
// htm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module htm_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/htm_front.sv
// ----------------------------------------------------------------------------
// htm_front
// Accepts requests, looks up the slot table and classifies each request.
// ----------------------------------------------------------------------------
module htm_front #(
    parameter int ENTRIES = htm_pkg::ENTRIES_DEFAULT,
    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    htm_req_if.sink            i_req,
    output logic               o_push,
    output htm_pkg::t_cmd      o_cmd,
    output logic [IDX_W-1:0]   o_idx,
    input  logic               i_q_full
);

    htm_pkg::t_fstate r_fstate, n_fstate;

    logic [2:0]                  r_req_type;
    logic [1:0]                  r_iface;
    logic [htm_pkg::WORD_W-1:0]  r_value;
    logic [ENTRIES-1:0]          r_match;

    logic [ENTRIES-1:0]            r_active;
    logic [ENTRIES-1:0]            r_full;
    logic [htm_pkg::HANDLE_W-1:0]  r_handle [ENTRIES];
    logic [htm_pkg::HANDLE_W-1:0]  r_hcnt;

    logic [IDX_W-1:0]             free_idx, hit_idx;
    logic                         free_any, hit_any, hit_full, add_ok, ok;
    logic [htm_pkg::HANDLE_W-1:0] hcnt_inc;
    htm_pkg::t_op                 op;
    logic                         accept, commit;

    assign i_req.ready = (r_fstate == htm_pkg::F_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign commit      = (r_fstate == htm_pkg::F_EXEC) && !i_q_full;

    always_comb begin
        free_idx = '0;
        hit_idx  = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                free_idx = IDX_W'(i);
            end
            if (r_match[i]) begin
                hit_idx = IDX_W'(i);
            end
        end
    end

    assign free_any = !(&r_active);
    assign hit_any  = |r_match;
    assign hit_full = |(r_match & r_full);
    assign hcnt_inc = r_hcnt + 32'd1;
    assign add_ok   = (r_iface <= htm_pkg::TYPE_MAX) && (r_hcnt != htm_pkg::HANDLE_MAX)
                      && free_any;

    always_comb begin
        n_fstate = r_fstate;
        ok       = 1'b0;
        op       = htm_pkg::OP_FAIL;
        case (r_req_type)
            htm_pkg::REQ_ADD: begin
                ok = add_ok;
                op = htm_pkg::OP_ADD;
            end
            htm_pkg::REQ_DEL: begin
                ok = hit_any;
                op = htm_pkg::OP_DEL;
            end
            htm_pkg::REQ_SEND: begin
                ok = hit_any && !hit_full;
                op = htm_pkg::OP_SEND;
            end
            htm_pkg::REQ_RECV: begin
                ok = hit_any && hit_full;
                op = htm_pkg::OP_RECV;
            end
            htm_pkg::REQ_STAT: begin
                ok = hit_any;
                op = htm_pkg::OP_STAT;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
        if (!ok) begin
            op = htm_pkg::OP_FAIL;
        end
        case (r_fstate)
            htm_pkg::F_IDLE: begin
                if (accept) begin
                    n_fstate = htm_pkg::F_EXEC;
                end
            end
            htm_pkg::F_EXEC: begin
                if (commit) begin
                    n_fstate = htm_pkg::F_IDLE;
                end
            end
            default: begin
                n_fstate = htm_pkg::F_IDLE;
            end
        endcase
    end

    assign o_push           = commit;
    assign o_cmd.op         = op;
    assign o_cmd.new_handle = (op == htm_pkg::OP_ADD) ? hcnt_inc : '0;
    assign o_cmd.value      = r_value;
    assign o_idx            = (r_req_type == htm_pkg::REQ_ADD) ? free_idx : hit_idx;

    // control state of the table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fstate <= htm_pkg::F_IDLE;
            r_active <= '0;
            r_full   <= '0;
            r_hcnt   <= '0;
        end else begin
            r_fstate <= n_fstate;
            if (commit) begin
                case (op)
                    htm_pkg::OP_ADD: begin
                        r_active[free_idx] <= 1'b1;
                        r_full[free_idx]   <= 1'b0;
                        r_hcnt             <= hcnt_inc;
                    end
                    htm_pkg::OP_DEL: begin
                        r_active[hit_idx] <= 1'b0;
                    end
                    htm_pkg::OP_SEND: begin
                        r_full[hit_idx] <= 1'b1;
                    end
                    htm_pkg::OP_RECV: begin
                        r_full[hit_idx] <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // request capture and handle compare against every slot
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req_type <= i_req.req_type;
            r_iface    <= i_req.iface_type;
            r_value    <= i_req.send_value;
            for (int i = 0; i < ENTRIES; i++) begin
                r_match[i] <= r_active[i] && (r_handle[i] == i_req.handle);
            end
        end
        if (commit && (op == htm_pkg::OP_ADD)) begin
            r_handle[free_idx] <= hcnt_inc;
        end
    end

endmodule

// File: src/htm_queue.sv
// ----------------------------------------------------------------------------
// htm_queue
// Small FIFO carrying classified commands from the front to the back.
// ----------------------------------------------------------------------------
module htm_queue #(
    parameter int W     = 8,
    parameter int DEPTH = htm_pkg::QUEUE_DEPTH,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: src/htm_back.sv
// ----------------------------------------------------------------------------
// htm_back
// Carries out classified commands on the mailbox and counter memories.
// ----------------------------------------------------------------------------
module htm_back #(
    parameter int ENTRIES = htm_pkg::ENTRIES_DEFAULT,
    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  htm_pkg::t_cmd    i_cmd,
    input  logic [IDX_W-1:0] i_idx,
    output logic             o_pop,
    htm_rsp_if.source        o_rsp
);

    htm_pkg::t_bstate r_bstate, n_bstate;

    htm_pkg::t_cmd    r_cmd;
    logic [IDX_W-1:0] r_idx;

    logic [htm_pkg::WORD_W-1:0] word_q;
    logic [htm_pkg::CNT_W-1:0]  scnt_q, rcnt_q;
    logic                       word_we, scnt_we, rcnt_we;
    logic [htm_pkg::CNT_W-1:0]  scnt_wdata, rcnt_wdata;

    logic                          r_out_valid;
    logic                          r_status;
    logic [htm_pkg::HANDLE_W-1:0]  r_new_handle;
    logic [htm_pkg::WORD_W-1:0]    r_recv_value;
    logic [htm_pkg::CNT_W-1:0]     r_sent_total, r_recv_total;

    logic can_out, finish;

    function automatic logic [htm_pkg::CNT_W-1:0] sat_inc(
        input logic [htm_pkg::CNT_W-1:0] v
    );
        return (v == htm_pkg::CNT_MAX) ? v : v + 32'd1;
    endfunction

    assign can_out = !r_out_valid || o_rsp.ready;
    assign finish  = (r_bstate == htm_pkg::B_EXEC) && can_out;
    assign o_pop   = (r_bstate == htm_pkg::B_IDLE) && i_q_valid;

    always_comb begin
        n_bstate   = r_bstate;
        word_we    = 1'b0;
        scnt_we    = 1'b0;
        rcnt_we    = 1'b0;
        scnt_wdata = '0;
        rcnt_wdata = '0;
        case (r_bstate)
            htm_pkg::B_IDLE: begin
                if (i_q_valid) begin
                    n_bstate = htm_pkg::B_EXEC;
                end
            end
            htm_pkg::B_EXEC: begin
                if (can_out) begin
                    n_bstate = htm_pkg::B_IDLE;
                    case (r_cmd.op)
                        htm_pkg::OP_ADD: begin
                            // fresh slot starts with zero counters
                            scnt_we = 1'b1;
                            rcnt_we = 1'b1;
                        end
                        htm_pkg::OP_SEND: begin
                            word_we    = 1'b1;
                            scnt_we    = 1'b1;
                            scnt_wdata = sat_inc(scnt_q);
                        end
                        htm_pkg::OP_RECV: begin
                            rcnt_we    = 1'b1;
                            rcnt_wdata = sat_inc(rcnt_q);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_bstate = htm_pkg::B_IDLE;
            end
        endcase
    end

    htm_ram #(.W(htm_pkg::WORD_W), .DEPTH(ENTRIES)) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (word_we),
        .i_waddr (r_idx),
        .i_wdata (r_cmd.value),
        .i_re    (o_pop),
        .i_raddr (i_idx),
        .o_rdata (word_q)
    );

    htm_ram #(.W(htm_pkg::CNT_W), .DEPTH(ENTRIES)) u_scnt_ram (
        .i_clk   (i_clk),
        .i_we    (scnt_we),
        .i_waddr (r_idx),
        .i_wdata (scnt_wdata),
        .i_re    (o_pop),
        .i_raddr (i_idx),
        .o_rdata (scnt_q)
    );

    htm_ram #(.W(htm_pkg::CNT_W), .DEPTH(ENTRIES)) u_rcnt_ram (
        .i_clk   (i_clk),
        .i_we    (rcnt_we),
        .i_waddr (r_idx),
        .i_wdata (rcnt_wdata),
        .i_re    (o_pop),
        .i_raddr (i_idx),
        .o_rdata (rcnt_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bstate    <= htm_pkg::B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_bstate <= n_bstate;
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
            r_idx <= i_idx;
        end
        if (finish) begin
            r_status     <= (r_cmd.op == htm_pkg::OP_FAIL);
            r_new_handle <= r_cmd.new_handle;
            r_recv_value <= (r_cmd.op == htm_pkg::OP_RECV) ? word_q : '0;
            r_sent_total <= (r_cmd.op == htm_pkg::OP_STAT) ? scnt_q : '0;
            r_recv_total <= (r_cmd.op == htm_pkg::OP_STAT) ? rcnt_q : '0;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_status;
    assign o_rsp.new_handle = r_new_handle;
    assign o_rsp.recv_value = r_recv_value;
    assign o_rsp.sent_total = r_sent_total;
    assign o_rsp.recv_total = r_recv_total;

endmodule

// File: src/handle_table_mailbox.sv
// ----------------------------------------------------------------------------
// handle_table_mailbox
// Handle table of slots with one-word mailboxes and saturating counters.
// ----------------------------------------------------------------------------
// A request (add, delete, send, receive, statistics) is taken only while the
// front is idle: the front captures it and compares its handle against all
// slots, then decides the outcome and updates active marks, full flags and
// the handle counter once it can push to the queue. The classified command
// goes through a two-entry queue to the back, which handles each command in
// two steps (a registered read of the mailbox and counter memories, then the
// write-back and the result register) and takes no new command until it is
// through with the last one. Every request gives exactly one result; on
// failure all fields but status are 0.
// No clearing pass is needed after reset.
module handle_table_mailbox #(
    parameter int ENTRIES = htm_pkg::ENTRIES_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    htm_req_if.sink   i_req,
    htm_rsp_if.source o_rsp
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int QW    = $bits(htm_pkg::t_cmd) + IDX_W;

    logic             push, q_full, q_valid, pop;
    htm_pkg::t_cmd    push_cmd, pop_cmd;
    logic [IDX_W-1:0] push_idx, pop_idx;

    htm_front #(.ENTRIES(ENTRIES)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .o_push   (push),
        .o_cmd    (push_cmd),
        .o_idx    (push_idx),
        .i_q_full (q_full)
    );

    htm_queue #(.W(QW), .DEPTH(htm_pkg::QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({push_cmd, push_idx}),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  ({pop_cmd, pop_idx})
    );

    htm_back #(.ENTRIES(ENTRIES)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (pop_cmd),
        .i_idx     (pop_idx),
        .o_pop     (pop),
        .o_rsp     (o_rsp)
    );

endmodule
